// ----- rtl/bipp_pkg.sv -----
// Shared types and constants for the projection profile peak finder.
`default_nettype none
package bipp_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 11;  // per-row white count
    localparam int COL_W     = 10;  // per-column white count
    localparam int TOT_W     = 20;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 10;
    localparam int THR_W     = 16;
    localparam int STEP_W    = 7;
    localparam int SKIP_W    = 8;
    localparam int IDX_W     = 12;  // sweep, clear and scan index
    localparam int FND_W     = 6;   // peak count, saturates one above the peak limit
    localparam int PROD_W    = THR_W + STEP_W;
    localparam int TDATA_W   = 88;
    localparam int TUSER_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [PIX_W-1:0] WHITE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 3'd4;

    localparam logic [1:0] KIND_SUM = 2'd0;
    localparam logic [1:0] KIND_ROW = 2'd1;
    localparam logic [1:0] KIND_COL = 2'd2;

    // emission phase
    localparam logic [1:0] EPH_SUM  = 2'd0;
    localparam logic [1:0] EPH_ROW  = 2'd1;
    localparam logic [1:0] EPH_COL  = 2'd2;
    localparam logic [1:0] EPH_DONE = 2'd3;

    typedef struct packed {
        logic px_accept;
        logic col_wr;
        logic sweep;
        logic div_start;
        logic div_sel;     // 0: divide by height, 1: by width
        logic scan_init;
        logic win_init;
        logic win_run;
        logic eval;
        logic axis;        // 0: row profile, 1: column profile
        logic clear_init;
        logic clear;
        logic emit_init;
        logic emit_load;
    } bipp_cmd_t;

    typedef struct packed {
        logic white;
        logic frame_end;
        logic sweep_done;
        logic div_done;
        logic scan_more;
        logic win_done;
        logic clr_last;
        logic emit_done;
        logic out_free;
    } bipp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bipp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bipp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/bipp_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bipp_div (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               start,
    input  wire  [bipp_pkg::TOT_W-1:0]        dividend,
    input  wire  [bipp_pkg::WID_W-1:0]        divisor,
    output logic [bipp_pkg::TOT_W-1:0]        quotient,
    output logic                              done
);

    logic                        busy_reg;
    logic [4:0]                  cnt_reg;
    logic [bipp_pkg::WID_W:0]    rem_reg;
    logic [bipp_pkg::TOT_W-1:0]  q_reg;
    logic                        done_reg;
    logic [bipp_pkg::WID_W:0]    trial;
    logic                        ge;

    assign trial    = {rem_reg[bipp_pkg::WID_W-1:0], q_reg[bipp_pkg::TOT_W-1]};
    assign ge       = trial >= {1'b0, divisor};
    assign quotient = q_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(bipp_pkg::TOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? trial - {1'b0, divisor} : trial;
            q_reg   <= {q_reg[bipp_pkg::TOT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bipp_datapath.sv -----
// Datapath: config registers, count stores, sweep, scan, divider and output register.
`default_nettype none
module bipp_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_PEAKS  = 31
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [bipp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [bipp_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  wire  [bipp_pkg::PIX_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [bipp_pkg::TDATA_W-1:0]        m_tdata,
    output logic [bipp_pkg::TUSER_W-1:0]        m_tuser,
    output logic                                m_tlast,
    input  bipp_pkg::bipp_cmd_t                 cmd,
    output bipp_pkg::bipp_stat_t                stat
);

    localparam int RAW      = $clog2(MAX_HEIGHT);
    localparam int CAW      = $clog2(MAX_WIDTH);
    localparam int PW       = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int WCAP     = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int HCAP     = (MAX_HEIGHT > 1023) ? 1023 : MAX_HEIGHT;
    localparam int CLR_LEN  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam logic [10:0] WMAX      = 11'(WCAP);
    localparam logic [9:0]  HMAX      = 10'(HCAP);
    localparam logic [11:0] CLR_LAST  = 12'(CLR_LEN - 1);
    localparam logic [12:0] ROW_DEPTH = 13'(MAX_HEIGHT);
    localparam logic [12:0] COL_DEPTH = 13'(MAX_WIDTH);
    localparam logic [5:0]  MAXP      = 6'(MAX_PEAKS);

    // configuration
    logic [10:0] cfg_w_reg;
    logic [9:0]  cfg_h_reg;
    logic [15:0] cfg_thr_reg;
    logic [6:0]  cfg_step_reg;
    logic [7:0]  cfg_skip_reg;

    logic [10:0] w_eff;
    logic [9:0]  h_eff;
    logic [6:0]  step_eff;

    assign cfg_ready = 1'b1;
    assign w_eff    = (cfg_w_reg == 11'd0) ? 11'd1 : ((cfg_w_reg > WMAX) ? WMAX : cfg_w_reg);
    assign h_eff    = (cfg_h_reg == 10'd0) ? 10'd1 : ((cfg_h_reg > HMAX) ? HMAX : cfg_h_reg);
    assign step_eff = (cfg_step_reg == 7'd0) ? 7'd1 : cfg_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg    <= 11'd1024;
            cfg_h_reg    <= 10'd512;
            cfg_thr_reg  <= 16'd16;
            cfg_step_reg <= 7'd3;
            cfg_skip_reg <= 8'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                bipp_pkg::CFG_WIDTH:  cfg_w_reg    <= cfg_data[10:0];
                bipp_pkg::CFG_HEIGHT: cfg_h_reg    <= cfg_data[9:0];
                bipp_pkg::CFG_THRESH: cfg_thr_reg  <= cfg_data;
                bipp_pkg::CFG_STEP:   cfg_step_reg <= cfg_data[6:0];
                bipp_pkg::CFG_SKIP:   cfg_skip_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pixel path state
    logic [10:0] x_reg;
    logic [9:0]  y_reg;
    logic [10:0] rowcnt_reg;
    logic [19:0] total_reg;
    logic [19:0] sum_tot_reg;
    logic [10:0] colx_reg;

    logic        white;
    logic        row_end;
    logic        frame_end;
    logic [10:0] rowcnt_inc;
    logic [19:0] total_inc;

    assign white      = s_tdata == bipp_pkg::WHITE;
    assign row_end    = ({1'b0, x_reg} + 12'd1) >= {1'b0, w_eff};
    assign frame_end  = row_end && (({1'b0, y_reg} + 11'd1) >= {1'b0, h_eff});
    assign rowcnt_inc = (white && rowcnt_reg != 11'h7FF) ? rowcnt_reg + 11'd1 : rowcnt_reg;
    assign total_inc  = (white && total_reg != 20'hFFFFF) ? total_reg + 20'd1 : total_reg;

    // shared counters and scan state
    logic [11:0] cnt_reg;
    logic [11:0] i_reg;
    logic [1:0]  j_reg;
    logic        rdv_reg;
    logic        inr_reg;
    logic        swv_reg;
    logic        sw_row_ok_reg;
    logic        sw_col_ok_reg;
    logic [10:0] mx_reg;
    logic [10:0] mn_reg;
    logic [10:0] rm_reg;
    logic [9:0]  cm_reg;
    logic [22:0] prod_reg;
    logic [5:0]  frow_reg;
    logic [5:0]  fcol_reg;
    logic [10:0] qh_reg;
    logic [9:0]  qw_reg;

    logic [10:0] sweep_len;
    logic        sweep_issue;
    logic [10:0] len;
    logic [11:0] scan_addr;
    logic        win_issue;
    logic [10:0] row_rdata;
    logic [9:0]  col_rdata;
    logic [10:0] win_val;
    logic [10:0] rise;
    logic        hit;
    logic [5:0]  fsel;

    assign sweep_len   = (w_eff > {1'b0, h_eff}) ? w_eff : {1'b0, h_eff};
    assign sweep_issue = {1'b0, cnt_reg} < {2'b0, sweep_len};
    assign len         = cmd.axis ? w_eff : {1'b0, h_eff};
    assign scan_addr   = i_reg + {10'b0, j_reg};
    assign win_issue   = j_reg != 2'd3;
    assign win_val     = inr_reg ? (cmd.axis ? {1'b0, col_rdata} : row_rdata) : 11'd0;
    assign rise        = mx_reg - mn_reg;
    assign hit         = {8'b0, rise, 4'b0} > prod_reg;
    assign fsel        = cmd.axis ? fcol_reg : frow_reg;

    // count stores
    logic             row_we;
    logic [RAW-1:0]   row_waddr;
    logic [10:0]      row_wdata;
    logic [RAW-1:0]   row_raddr;
    logic             col_we;
    logic [CAW-1:0]   col_waddr;
    logic [9:0]       col_wdata;
    logic [CAW-1:0]   col_raddr;
    logic [11:0]      row_waddr_full;
    logic [11:0]      col_waddr_full;
    logic [11:0]      row_raddr_full;
    logic [11:0]      col_raddr_full;

    assign row_we = (cmd.px_accept && row_end) ||
                    (cmd.clear && ({1'b0, cnt_reg} < ROW_DEPTH));
    assign row_waddr_full = cmd.clear ? cnt_reg : {2'b0, y_reg};
    assign row_wdata      = cmd.clear ? 11'd0 : rowcnt_inc;
    assign row_raddr_full = cmd.sweep ? cnt_reg : scan_addr;
    assign col_we = cmd.col_wr || (cmd.clear && ({1'b0, cnt_reg} < COL_DEPTH));
    assign col_waddr_full = cmd.clear ? cnt_reg : {1'b0, colx_reg};
    assign col_wdata      = cmd.clear ? 10'd0 :
                            ((col_rdata == 10'h3FF) ? col_rdata : col_rdata + 10'd1);
    assign col_raddr_full = cmd.px_accept ? {1'b0, x_reg} : (cmd.sweep ? cnt_reg : scan_addr);
    assign row_waddr = row_waddr_full[RAW-1:0];
    assign row_raddr = row_raddr_full[RAW-1:0];
    assign col_waddr = col_waddr_full[CAW-1:0];
    assign col_raddr = col_raddr_full[CAW-1:0];

    bipp_ram #(.WIDTH(bipp_pkg::ROW_W), .DEPTH(MAX_HEIGHT)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    bipp_ram #(.WIDTH(bipp_pkg::COL_W), .DEPTH(MAX_WIDTH)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // averages
    logic [19:0] quot;
    logic        div_done;

    bipp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_tot_reg),
        .divisor  (cmd.div_sel ? w_eff : {1'b0, h_eff}),
        .quotient (quot),
        .done     (div_done)
    );

    // peak buffers
    logic [21:0] row_buf_reg [MAX_PEAKS];
    logic [21:0] col_buf_reg [MAX_PEAKS];

    always_ff @(posedge aclk) begin
        if (cmd.eval && hit && fsel < MAXP) begin
            if (cmd.axis) begin
                col_buf_reg[fsel[PW-1:0]] <= {mx_reg, rise};
            end else begin
                row_buf_reg[fsel[PW-1:0]] <= {mx_reg, rise};
            end
        end
    end

    // emission sequencing
    logic [1:0]  ph_reg;
    logic [5:0]  ptr_reg;
    logic [1:0]  ph_next;
    logic [5:0]  ptr_next;
    logic [5:0]  nr;
    logic [5:0]  nc;
    logic [1:0]  item_kind;
    logic [87:0] item_data;
    logic [21:0] row_item;
    logic [21:0] col_item;
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        m_tlast_reg;

    assign nr       = (frow_reg > MAXP) ? MAXP : frow_reg;
    assign nc       = (fcol_reg > MAXP) ? MAXP : fcol_reg;
    assign row_item = row_buf_reg[ptr_reg[PW-1:0]];
    assign col_item = col_buf_reg[ptr_reg[PW-1:0]];

    always_comb begin
        ph_next   = bipp_pkg::EPH_DONE;
        ptr_next  = 6'd0;
        item_kind = bipp_pkg::KIND_SUM;
        item_data = '0;
        case (ph_reg)
            bipp_pkg::EPH_SUM: begin
                item_data[19:0]  = sum_tot_reg;
                item_data[30:20] = qh_reg;
                item_data[40:31] = qw_reg;
                item_data[51:41] = rm_reg;
                item_data[61:52] = cm_reg;
                if (nr != 6'd0) begin
                    ph_next = bipp_pkg::EPH_ROW;
                end else if (nc != 6'd0) begin
                    ph_next = bipp_pkg::EPH_COL;
                end
            end
            bipp_pkg::EPH_ROW: begin
                item_kind        = bipp_pkg::KIND_ROW;
                item_data[72:62] = row_item[21:11];
                item_data[83:73] = row_item[10:0];
                item_data[84]    = frow_reg > MAXP;
                if (ptr_reg + 6'd1 < nr) begin
                    ph_next  = bipp_pkg::EPH_ROW;
                    ptr_next = ptr_reg + 6'd1;
                end else if (nc != 6'd0) begin
                    ph_next = bipp_pkg::EPH_COL;
                end
            end
            bipp_pkg::EPH_COL: begin
                item_kind        = bipp_pkg::KIND_COL;
                item_data[72:62] = col_item[21:11];
                item_data[83:73] = col_item[10:0];
                item_data[84]    = fcol_reg > MAXP;
                if (ptr_reg + 6'd1 < nc) begin
                    ph_next  = bipp_pkg::EPH_COL;
                    ptr_next = ptr_reg + 6'd1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= '0;
            y_reg        <= '0;
            rowcnt_reg   <= '0;
            total_reg    <= '0;
            cnt_reg      <= '0;
            j_reg        <= 2'd3;
            rdv_reg      <= 1'b0;
            swv_reg      <= 1'b0;
            frow_reg     <= '0;
            fcol_reg     <= '0;
            ph_reg       <= bipp_pkg::EPH_DONE;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.px_accept) begin
                if (row_end) begin
                    x_reg      <= '0;
                    rowcnt_reg <= '0;
                    y_reg      <= frame_end ? 10'd0 : y_reg + 10'd1;
                end else begin
                    x_reg      <= x_reg + 11'd1;
                    rowcnt_reg <= rowcnt_inc;
                end
                total_reg <= frame_end ? 20'd0 : total_inc;
                if (frame_end) begin
                    cnt_reg <= '0;
                    swv_reg <= 1'b0;
                end
            end
            if (cmd.sweep) begin
                swv_reg <= sweep_issue;
                if (sweep_issue) begin
                    cnt_reg <= cnt_reg + 12'd1;
                end
            end
            if (cmd.clear_init) begin
                cnt_reg <= '0;
            end
            if (cmd.clear) begin
                cnt_reg <= cnt_reg + 12'd1;
            end
            if (cmd.div_start && !cmd.div_sel) begin
                frow_reg <= '0;
                fcol_reg <= '0;
            end
            if (cmd.win_init) begin
                j_reg   <= 2'd0;
                rdv_reg <= 1'b0;
            end
            if (cmd.win_run) begin
                rdv_reg <= win_issue;
                if (win_issue) begin
                    j_reg <= j_reg + 2'd1;
                end
            end
            if (cmd.eval && hit && fsel <= MAXP) begin
                if (cmd.axis) begin
                    fcol_reg <= fcol_reg + 6'd1;
                end else begin
                    frow_reg <= frow_reg + 6'd1;
                end
            end
            if (cmd.emit_init) begin
                ph_reg  <= bipp_pkg::EPH_SUM;
                ptr_reg <= '0;
            end
            if (cmd.emit_load) begin
                ph_reg       <= ph_next;
                ptr_reg      <= ptr_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= 23'(cfg_thr_reg) * 23'(step_eff);
        if (cmd.px_accept) begin
            colx_reg <= x_reg;
            if (frame_end) begin
                sum_tot_reg <= total_inc;
                rm_reg      <= '0;
                cm_reg      <= '0;
            end
        end
        if (cmd.sweep) begin
            sw_row_ok_reg <= {1'b0, cnt_reg} < {3'b0, h_eff};
            sw_col_ok_reg <= {1'b0, cnt_reg} < {2'b0, w_eff};
            if (swv_reg) begin
                if (sw_row_ok_reg && row_rdata > rm_reg) begin
                    rm_reg <= row_rdata;
                end
                if (sw_col_ok_reg && col_rdata > cm_reg) begin
                    cm_reg <= col_rdata;
                end
            end
        end
        if (div_done) begin
            if (cmd.div_sel) begin
                qw_reg <= quot[9:0];
            end else begin
                qh_reg <= quot[10:0];
            end
        end
        if (cmd.scan_init) begin
            i_reg <= '0;
        end
        if (cmd.win_init) begin
            mx_reg <= '0;
            mn_reg <= '1;
        end
        if (cmd.win_run) begin
            inr_reg <= {1'b0, scan_addr} < {2'b0, len};
            if (rdv_reg) begin
                if (win_val > mx_reg) begin
                    mx_reg <= win_val;
                end
                if (win_val < mn_reg) begin
                    mn_reg <= win_val;
                end
            end
        end
        if (cmd.eval) begin
            i_reg <= i_reg + {5'b0, step_eff} + (hit ? {4'b0, cfg_skip_reg} : 12'd0);
        end
        if (cmd.emit_load) begin
            m_tdata_reg <= item_data;
            m_tuser_reg <= item_kind;
            m_tlast_reg <= ph_next == bipp_pkg::EPH_DONE;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat.white      = white;
    assign stat.frame_end  = frame_end;
    assign stat.sweep_done = !sweep_issue;
    assign stat.div_done   = div_done;
    assign stat.scan_more  = ({1'b0, i_reg} + {6'b0, step_eff}) < {2'b0, len};
    assign stat.win_done   = j_reg == 2'd3;
    assign stat.clr_last   = cnt_reg == CLR_LAST;
    assign stat.emit_done  = ph_reg == bipp_pkg::EPH_DONE;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

`ifndef NO_ASSERTIONS
    a_x_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        x_reg < WMAX || x_reg == 11'd0)
        else $error("column position beyond widest frame");
    a_found_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        frow_reg <= MAXP + 6'd1 && fcol_reg <= MAXP + 6'd1)
        else $error("peak count passed its saturation point");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load && ph_next == bipp_pkg::EPH_DONE) |=> (m_tvalid && m_tlast))
        else $error("final result of frame not flagged");
`endif

endmodule
`default_nettype wire

// ----- rtl/bipp_ctrl.sv -----
// Controller: sequences pixel intake, frame-end sweep, divides, scans, clearing and output.
`default_nettype none
module bipp_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  bipp_pkg::bipp_stat_t  stat,
    output bipp_pkg::bipp_cmd_t   cmd
);

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_COLWR     = 4'd2;
    localparam logic [3:0] ST_SWEEP     = 4'd3;
    localparam logic [3:0] ST_DIVH_GO   = 4'd4;
    localparam logic [3:0] ST_DIVH_WAIT = 4'd5;
    localparam logic [3:0] ST_DIVW_GO   = 4'd6;
    localparam logic [3:0] ST_DIVW_WAIT = 4'd7;
    localparam logic [3:0] ST_SCAN      = 4'd8;
    localparam logic [3:0] ST_WIN       = 4'd9;
    localparam logic [3:0] ST_EVAL      = 4'd10;
    localparam logic [3:0] ST_EMIT      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       fe_reg;
    logic       fe_next;
    logic       pend_reg;
    logic       pend_next;
    logic       axis_reg;
    logic       axis_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        fe_next    = fe_reg;
        pend_next  = pend_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clr_last) begin
                    pend_next = 1'b0;
                    if (pend_reg) begin
                        cmd.emit_init = 1'b1;
                        state_next    = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.px_accept = 1'b1;
                    fe_next       = stat.frame_end;
                    if (stat.white) begin
                        state_next = ST_COLWR;
                    end else if (stat.frame_end) begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_COLWR: begin
                cmd.col_wr = 1'b1;
                state_next = fe_reg ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_DIVH_GO;
                end
            end
            ST_DIVH_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVH_WAIT;
            end
            ST_DIVH_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_DIVW_GO;
                end
            end
            ST_DIVW_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_DIVW_WAIT;
            end
            ST_DIVW_WAIT: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.scan_init = 1'b1;
                    axis_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_more) begin
                    cmd.win_init = 1'b1;
                    state_next   = ST_WIN;
                end else if (!axis_reg) begin
                    // row profile done, move to the column profile
                    cmd.scan_init = 1'b1;
                    axis_next     = 1'b1;
                end else begin
                    cmd.clear_init = 1'b1;
                    pend_next      = 1'b1;
                    state_next     = ST_CLEAR;
                end
            end
            ST_WIN: begin
                cmd.win_run = 1'b1;
                if (stat.win_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_EMIT: begin
                cmd.emit_load = stat.out_free && !stat.emit_done;
                if (stat.emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fe_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fe_reg    <= fe_next;
            pend_reg  <= pend_next;
            axis_reg  <= axis_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("idle with a frame still pending");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == ST_DIVH_WAIT || state_reg == ST_DIVW_WAIT))
        else $error("divider finished outside a wait state");
    a_emit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_init |-> stat.emit_done)
        else $error("new frame results started over unfinished ones");
`endif

endmodule
`default_nettype wire

// ----- rtl/binary_image_projection_peaks_top.sv -----
// Projection profile peak finder: white-pixel counts per row and column, summary and peaks.
//
// Channels: pixels enter on s_tvalid/s_tready/s_tdata in raster order, one
// 8-bit pixel per item. Results leave on m_tvalid/m_tready with m_tdata,
// m_tuser (kind) and m_tlast (final result of the frame). Configuration is
// written through cfg_valid/cfg_ready/cfg_index/cfg_data, always ready.
// Intake: a white pixel holds off the next pixel for the read-modify-write
// of its column count in the column store; a non-white pixel does not.
// At the frame's last pixel the block stops taking pixels and runs: a max
// sweep over max(height, width) entries, two divides (start, 20 quotient
// bits, finish), the row and column peak scans, and a clear pass of
// max(MAX_WIDTH, MAX_HEIGHT) entries over both count stores. Then the
// summary and the peak items are sent, one per cycle while the receiver
// takes them.
// Reset runs the same clear pass before the first pixel is accepted.
// A stalled receiver holds the output register; the block takes pixels
// again once the last item of the frame sits in that register.
`default_nettype none
module binary_image_projection_peaks_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_PEAKS  = 31
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [bipp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [bipp_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bipp_pkg::PIX_W-1:0]        s_tdata,   // pixel
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // total_white, row_average, col_average, row_max, col_max,
    // peak_height, peak_rise, truncated, zero fill
    output logic [bipp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [bipp_pkg::TUSER_W-1:0]      m_tuser,   // kind
    output logic                              m_tlast
);

    bipp_pkg::bipp_cmd_t  cmd;
    bipp_pkg::bipp_stat_t stat;

    bipp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bipp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PEAKS  (MAX_PEAKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire
